### hdl/plrt_pkg.sv
// Shared types and constants for the pinned LRU residency table.
`default_nettype none
package plrt_pkg;

    localparam int KEY_IN_W = 32;
    localparam int BYTE_W   = 40;
    localparam int TOK_W    = 48;
    localparam int HIT_W    = 32;
    localparam int ECNT_W   = 7;
    localparam int CMD_W    = 2;

    localparam logic [CMD_W-1:0] CMD_ENSURE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TOUCH  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PROBE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;

    localparam logic [ECNT_W-1:0] ECNT_MAX = 7'd127;
    localparam logic [HIT_W-1:0]  HIT_MAX  = 32'hFFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic scan_start;
        logic scan_victim;
        logic set_hit;
        logic refresh;
        logic cnt_hit;
        logic cnt_miss;
        logic evict;
        logic admit;
        logic emit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             scan_done;
        logic             found;
        logic [CMD_W-1:0] cmd;
        logic             can_admit;
        logic             need_evict;
        logic             out_busy;
    } ctl_sts_t;

endpackage
`default_nettype wire

### hdl/plrt_if.sv
// Channel interfaces for requests, results and the capacity register.
`default_nettype none
interface plrt_req_if;
    logic                           valid;
    logic                           ready;
    logic [plrt_pkg::CMD_W-1:0]     cmd;
    logic [plrt_pkg::KEY_IN_W-1:0]  entry_key;
    logic [plrt_pkg::BYTE_W-1:0]    entry_bytes;
    logic [plrt_pkg::TOK_W-1:0]     use_token;
    logic                           pin_request;
    modport source (output valid, cmd, entry_key, entry_bytes, use_token, pin_request,
                    input ready);
    modport sink (input valid, cmd, entry_key, entry_bytes, use_token, pin_request,
                  output ready);
endinterface

interface plrt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         was_hit;
    logic                         admitted;
    logic [plrt_pkg::ECNT_W-1:0]  evicted_count;
    logic [plrt_pkg::BYTE_W-1:0]  evicted_bytes;
    logic [plrt_pkg::HIT_W-1:0]   hit_total;
    logic [plrt_pkg::HIT_W-1:0]   miss_total;
    modport source (output valid, was_hit, admitted, evicted_count, evicted_bytes,
                    hit_total, miss_total, input ready);
    modport sink (input valid, was_hit, admitted, evicted_count, evicted_bytes,
                  hit_total, miss_total, output ready);
endinterface

interface plrt_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [plrt_pkg::BYTE_W-1:0]  data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### hdl/plrt_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module plrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hdl/plrt_ctrl.sv
// Controller state machine that sequences lookup, eviction and admission.
`default_nettype none
module plrt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire plrt_pkg::ctl_sts_t  sts,
    output plrt_pkg::ctl_cmd_t       cmd
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_VSCAN  = 3'd4;
    localparam logic [2:0] S_EVICT  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in    = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.set_hit = 1'b1;
                state_next  = S_FINISH;
                unique case (sts.cmd)
                    plrt_pkg::CMD_TOUCH:
                    begin
                        cmd.refresh = sts.found;
                    end
                    plrt_pkg::CMD_ENSURE:
                    begin
                        if (sts.found)
                        begin
                            cmd.refresh = 1'b1;
                            cmd.cnt_hit = 1'b1;
                        end
                        else
                        begin
                            cmd.cnt_miss = 1'b1;
                            if (sts.can_admit)
                            begin
                                state_next = S_CHECK;
                            end
                        end
                    end
                    default:
                    begin
                        cmd.refresh = 1'b0;
                    end
                endcase
            end
            S_CHECK:
            begin
                if (sts.need_evict)
                begin
                    cmd.scan_start  = 1'b1;
                    cmd.scan_victim = 1'b1;
                    state_next      = S_VSCAN;
                end
                else
                begin
                    cmd.admit  = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_VSCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.found ? S_EVICT : S_FINISH;
                end
            end
            S_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = S_CHECK;
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### hdl/plrt_dp.sv
// Datapath: slot memory, valid bits, scan unit, byte accounting and result register.
`default_nettype none
module plrt_dp #(
    parameter int SLOTS    = 64,
    parameter int KEY_BITS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire plrt_pkg::ctl_cmd_t                  cmd,
    output plrt_pkg::ctl_sts_t                       sts,
    input  wire logic [plrt_pkg::CMD_W-1:0]          in_cmd,
    input  wire logic [plrt_pkg::KEY_IN_W-1:0]       in_key,
    input  wire logic [plrt_pkg::BYTE_W-1:0]         in_bytes,
    input  wire logic [plrt_pkg::TOK_W-1:0]          in_token,
    input  wire logic                                in_pin,
    input  wire logic                                cfg_valid,
    input  wire logic [plrt_pkg::BYTE_W-1:0]         cfg_data,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic                                     out_was_hit,
    output logic                                     out_admitted,
    output logic [plrt_pkg::ECNT_W-1:0]              out_ecount,
    output logic [plrt_pkg::BYTE_W-1:0]              out_ebytes,
    output logic [plrt_pkg::HIT_W-1:0]               out_hit_total,
    output logic [plrt_pkg::HIT_W-1:0]               out_miss_total
);
    localparam int BW    = plrt_pkg::BYTE_W;
    localparam int TW    = plrt_pkg::TOK_W;
    localparam int HW    = plrt_pkg::HIT_W;
    localparam int IW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int REC_W = KEY_BITS + BW + TW + HW + 1;
    localparam int HIT_LO = 1;
    localparam int LU_LO  = HIT_LO + HW;
    localparam int BY_LO  = LU_LO + TW;
    localparam int KEY_LO = BY_LO + BW;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    logic [plrt_pkg::CMD_W-1:0] cmd_reg;
    logic [KEY_BITS-1:0]        key_reg;
    logic [BW-1:0]              bytes_reg;
    logic [TW-1:0]              tok_reg;
    logic                       pin_reg;
    logic [BW-1:0]              cap_reg, used_reg;
    logic [HW-1:0]              hit_cnt_reg, miss_cnt_reg;
    logic [SLOTS-1:0]           valid_reg;
    logic                       was_hit_reg, adm_reg;
    logic [plrt_pkg::ECNT_W-1:0] ecount_reg;
    logic [BW-1:0]              ebytes_reg;

    logic                       scan_on_reg, victim_reg, rd_pend_reg, fnd_reg;
    logic [CW-1:0]              cnt_reg;
    logic [IW-1:0]              rd_idx_reg, m_idx_reg;
    logic [REC_W-1:0]           m_rec_reg;

    logic [REC_W-1:0]           rdata, wdata;
    logic [IW-1:0]              waddr, free_idx;
    logic                       we, issue, scan_done, take;
    logic [63:0]                key_wide;
    logic [BW:0]                need_sum;
    logic [HW-1:0]              m_hits, r_hits;
    logic [TW-1:0]              m_lu, r_lu;
    logic [BW-1:0]              m_bytes;

    assign key_wide  = 64'(in_key);
    assign issue     = scan_on_reg && (cnt_reg != SLOTS_C);
    assign scan_done = scan_on_reg && (cnt_reg == SLOTS_C) && !rd_pend_reg;
    assign m_hits    = m_rec_reg[LU_LO-1:HIT_LO];
    assign m_lu      = m_rec_reg[BY_LO-1:LU_LO];
    assign m_bytes   = m_rec_reg[KEY_LO-1:BY_LO];
    assign r_hits    = rdata[LU_LO-1:HIT_LO];
    assign r_lu      = rdata[BY_LO-1:LU_LO];
    assign need_sum  = {1'b0, used_reg} + {1'b0, bytes_reg};

    // Candidate test for the slot whose data arrived this cycle.
    always_comb
    begin
        take = 1'b0;
        if (rd_pend_reg && valid_reg[rd_idx_reg])
        begin
            if (victim_reg)
            begin
                take = !rdata[0] && (!fnd_reg || (r_lu < m_lu) ||
                       ((r_lu == m_lu) && (r_hits < m_hits)));
            end
            else
            begin
                take = !fnd_reg && (rdata[REC_W-1:KEY_LO] == key_reg);
            end
        end
    end

    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        we    = cmd.refresh || cmd.admit;
        waddr = cmd.admit ? free_idx : m_idx_reg;
        if (cmd.admit)
        begin
            wdata = {key_reg, bytes_reg, tok_reg, {HW{1'b0}}, pin_reg};
        end
        else
        begin
            wdata = {m_rec_reg[REC_W-1:BY_LO], tok_reg,
                     (m_hits == plrt_pkg::HIT_MAX) ? m_hits : m_hits + 1'b1,
                     m_rec_reg[0] | (pin_reg && (cmd_reg == plrt_pkg::CMD_ENSURE))};
        end
    end

    plrt_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg   <= in_cmd;
            key_reg   <= key_wide[KEY_BITS-1:0];
            bytes_reg <= in_bytes;
            tok_reg   <= in_token;
            pin_reg   <= in_pin;
        end
        rd_idx_reg <= cnt_reg[IW-1:0];
        if (take)
        begin
            m_idx_reg <= rd_idx_reg;
            m_rec_reg <= rdata;
        end
        if (cmd.emit)
        begin
            out_was_hit    <= was_hit_reg;
            out_admitted   <= adm_reg;
            out_ecount     <= ecount_reg;
            out_ebytes     <= ebytes_reg;
            out_hit_total  <= hit_cnt_reg;
            out_miss_total <= miss_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= '0;
            used_reg     <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            valid_reg    <= '0;
            was_hit_reg  <= 1'b0;
            adm_reg      <= 1'b0;
            ecount_reg   <= '0;
            ebytes_reg   <= '0;
            scan_on_reg  <= 1'b0;
            victim_reg   <= 1'b0;
            rd_pend_reg  <= 1'b0;
            fnd_reg      <= 1'b0;
            cnt_reg      <= '0;
            out_valid    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.load_in)
            begin
                was_hit_reg <= 1'b0;
                adm_reg     <= 1'b0;
                ecount_reg  <= '0;
                ebytes_reg  <= '0;
            end
            if (cmd.scan_start)
            begin
                scan_on_reg <= 1'b1;
                victim_reg  <= cmd.scan_victim;
                fnd_reg     <= 1'b0;
                cnt_reg     <= '0;
                rd_pend_reg <= 1'b0;
            end
            else
            begin
                rd_pend_reg <= issue;
                if (issue)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (take)
                begin
                    fnd_reg <= 1'b1;
                end
                if (scan_done)
                begin
                    scan_on_reg <= 1'b0;
                end
            end
            if (cmd.set_hit)
            begin
                was_hit_reg <= fnd_reg && (cmd_reg != plrt_pkg::CMD_RSVD);
            end
            if (cmd.cnt_hit && (hit_cnt_reg != plrt_pkg::HIT_MAX))
            begin
                hit_cnt_reg <= hit_cnt_reg + 1'b1;
            end
            if (cmd.cnt_miss && (miss_cnt_reg != plrt_pkg::HIT_MAX))
            begin
                miss_cnt_reg <= miss_cnt_reg + 1'b1;
            end
            if (cmd.evict)
            begin
                valid_reg[m_idx_reg] <= 1'b0;
                ebytes_reg <= ebytes_reg + m_bytes;
                used_reg   <= (used_reg >= m_bytes) ? used_reg - m_bytes : '0;
                if (ecount_reg != plrt_pkg::ECNT_MAX)
                begin
                    ecount_reg <= ecount_reg + 1'b1;
                end
            end
            if (cmd.admit)
            begin
                valid_reg[free_idx] <= 1'b1;
                used_reg <= need_sum[BW-1:0];
                adm_reg  <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.scan_done  = scan_done;
        sts.found      = fnd_reg;
        sts.cmd        = cmd_reg;
        sts.can_admit  = (cap_reg != '0) && (bytes_reg <= cap_reg);
        sts.need_evict = (need_sum > {1'b0, cap_reg}) || (&valid_reg);
        sts.out_busy   = out_valid && !out_ready;
    end
endmodule
`default_nettype wire

### hdl/pinned_lru_residency_table_core.sv
// Top level of the pinned LRU residency table.
//
// Channels: req carries one request word (cmd, entry_key, entry_bytes,
// use_token, pin_request); rsp returns exactly one result word per request;
// cfg writes the byte capacity register and is always ready. Write it only
// while no request is in flight.
// Each request scans the slot memory one slot per cycle through its
// registered read port before the result is decided. An ensure miss that
// must evict repeats the fit check, the victim scan and the eviction for each
// evicted entry, then checks the fit once more and admits. One request is in
// flight at a time; req.ready is high only while the block is idle, so the
// next request is not taken until the previous result has been emitted.
// The result sits in an output register, so a new request may be taken while
// the previous result waits; if rsp stalls, the next result waits in its final
// state until the register drains.
// Reset clears all valid bits, the used byte count, the totals and the
// capacity register at once; no clearing pass is needed.
`default_nettype none
module pinned_lru_residency_table_core #(
    parameter int SLOTS    = 64,
    parameter int KEY_BITS = 32
) (
    input wire logic       clk,
    input wire logic       rst_n,
    plrt_req_if.sink       req,
    plrt_rsp_if.source     rsp,
    plrt_cfg_if.sink       cfg
);
    plrt_pkg::ctl_cmd_t ctl_cmd;
    plrt_pkg::ctl_sts_t ctl_sts;

    assign cfg.ready = 1'b1;

    plrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (ctl_sts),
        .cmd      (ctl_cmd)
    );

    plrt_dp #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl_cmd),
        .sts            (ctl_sts),
        .in_cmd         (req.cmd),
        .in_key         (req.entry_key),
        .in_bytes       (req.entry_bytes),
        .in_token       (req.use_token),
        .in_pin         (req.pin_request),
        .cfg_valid      (cfg.valid),
        .cfg_data       (cfg.data),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_was_hit    (rsp.was_hit),
        .out_admitted   (rsp.admitted),
        .out_ecount     (rsp.evicted_count),
        .out_ebytes     (rsp.evicted_bytes),
        .out_hit_total  (rsp.hit_total),
        .out_miss_total (rsp.miss_total)
    );
endmodule
`default_nettype wire

### hdl/plrt_checker.sv
// Port-level checker for the residency table and its bind statement.
`default_nettype none
module plrt_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic                         rsp_was_hit,
    input wire logic                         rsp_admitted,
    input wire logic [plrt_pkg::ECNT_W-1:0]  rsp_ecount,
    input wire logic [plrt_pkg::BYTE_W-1:0]  rsp_ebytes,
    input wire logic [plrt_pkg::HIT_W-1:0]   rsp_hit_total
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_hit_total))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while a lookup is in progress");

    a_admit_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_admitted |-> !rsp_was_hit)
        else $error("admitted entry reported as a hit");

    a_evict_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_ecount == '0) |-> (rsp_ebytes == '0))
        else $error("evicted bytes without evictions");
endmodule

bind pinned_lru_residency_table_core plrt_checker u_plrt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_was_hit   (rsp.was_hit),
    .rsp_admitted  (rsp.admitted),
    .rsp_ecount    (rsp.evicted_count),
    .rsp_ebytes    (rsp.evicted_bytes),
    .rsp_hit_total (rsp.hit_total)
);
`default_nettype wire
